[hw/rtl/wfd_pkg.sv]
// Shared types and constants for the WLAN frame duration calculator.
// Holds field widths, register reset values, the register map and the
// reciprocal table used by the pipelined rate divider. No dependencies.
`default_nettype none

package wfd_pkg;

   // Field widths.
   localparam int unsigned LEN_W   = 12;
   localparam int unsigned BODY_W  = 13;
   localparam int unsigned TXR_W   = 8;
   localparam int unsigned RATE_W  = 7;
   localparam int unsigned DUR_W   = 16;
   localparam int unsigned NUM_W   = 16;
   localparam int unsigned RECIP_W = 17;
   localparam int unsigned PROD_W  = NUM_W + RECIP_W;
   localparam int unsigned PRE_W   = 9;
   localparam int unsigned SIFS_W  = 8;
   localparam int unsigned OPRE_W  = 8;
   localparam int unsigned SYM_W   = 4;
   localparam int unsigned THR_W   = 12;

   // Stream and register port widths.
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned REQ_USER_W = 4;
   localparam int unsigned RSP_DATA_W = 32;
   localparam int unsigned RSP_USER_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 5;

   // Frame arithmetic constants.
   localparam int unsigned FCS_LEN        = 4;
   localparam int unsigned OFDM_EXTRA     = 22;
   localparam int unsigned RTS_DSSS_EXTRA = 14;
   localparam int unsigned DUR_DSSS_EXTRA = 28;
   localparam int unsigned ACK_BITS       = 112;

   // Register reset values.
   localparam int unsigned SIFS_RESET      = 10;
   localparam int unsigned OFDM_PRE_RESET  = 26;
   localparam int unsigned SYMBOL_RESET    = 4;
   localparam int unsigned LONG_PRE_RESET  = 192;
   localparam int unsigned SHORT_PRE_RESET = 96;
   localparam int unsigned RTS_THR_RESET   = 2347;
   localparam int unsigned PROTECT_RESET   = 0;

   // Register map, one 32-bit register every four bytes.
   typedef enum logic [2:0] {
      REG_SIFS      = 3'd0,
      REG_OFDM_PRE  = 3'd1,
      REG_SYMBOL    = 3'd2,
      REG_LONG_PRE  = 3'd3,
      REG_SHORT_PRE = 3'd4,
      REG_RTS_THR   = 3'd5,
      REG_PROTECT   = 3'd6
   } csr_index_type;

   // Reciprocal table: floor(2^16 / r) for rates 1..127. Entry zero is
   // never used because the rate is forced to at least one.
   localparam int unsigned RATE_DEPTH = 128;
   localparam int unsigned RECIP_ONE  = 65536;
   localparam int unsigned RECIP_TABLE [0:RATE_DEPTH-1] = '{
      RECIP_ONE,       RECIP_ONE / 1,   RECIP_ONE / 2,   RECIP_ONE / 3,
      RECIP_ONE / 4,   RECIP_ONE / 5,   RECIP_ONE / 6,   RECIP_ONE / 7,
      RECIP_ONE / 8,   RECIP_ONE / 9,   RECIP_ONE / 10,  RECIP_ONE / 11,
      RECIP_ONE / 12,  RECIP_ONE / 13,  RECIP_ONE / 14,  RECIP_ONE / 15,
      RECIP_ONE / 16,  RECIP_ONE / 17,  RECIP_ONE / 18,  RECIP_ONE / 19,
      RECIP_ONE / 20,  RECIP_ONE / 21,  RECIP_ONE / 22,  RECIP_ONE / 23,
      RECIP_ONE / 24,  RECIP_ONE / 25,  RECIP_ONE / 26,  RECIP_ONE / 27,
      RECIP_ONE / 28,  RECIP_ONE / 29,  RECIP_ONE / 30,  RECIP_ONE / 31,
      RECIP_ONE / 32,  RECIP_ONE / 33,  RECIP_ONE / 34,  RECIP_ONE / 35,
      RECIP_ONE / 36,  RECIP_ONE / 37,  RECIP_ONE / 38,  RECIP_ONE / 39,
      RECIP_ONE / 40,  RECIP_ONE / 41,  RECIP_ONE / 42,  RECIP_ONE / 43,
      RECIP_ONE / 44,  RECIP_ONE / 45,  RECIP_ONE / 46,  RECIP_ONE / 47,
      RECIP_ONE / 48,  RECIP_ONE / 49,  RECIP_ONE / 50,  RECIP_ONE / 51,
      RECIP_ONE / 52,  RECIP_ONE / 53,  RECIP_ONE / 54,  RECIP_ONE / 55,
      RECIP_ONE / 56,  RECIP_ONE / 57,  RECIP_ONE / 58,  RECIP_ONE / 59,
      RECIP_ONE / 60,  RECIP_ONE / 61,  RECIP_ONE / 62,  RECIP_ONE / 63,
      RECIP_ONE / 64,  RECIP_ONE / 65,  RECIP_ONE / 66,  RECIP_ONE / 67,
      RECIP_ONE / 68,  RECIP_ONE / 69,  RECIP_ONE / 70,  RECIP_ONE / 71,
      RECIP_ONE / 72,  RECIP_ONE / 73,  RECIP_ONE / 74,  RECIP_ONE / 75,
      RECIP_ONE / 76,  RECIP_ONE / 77,  RECIP_ONE / 78,  RECIP_ONE / 79,
      RECIP_ONE / 80,  RECIP_ONE / 81,  RECIP_ONE / 82,  RECIP_ONE / 83,
      RECIP_ONE / 84,  RECIP_ONE / 85,  RECIP_ONE / 86,  RECIP_ONE / 87,
      RECIP_ONE / 88,  RECIP_ONE / 89,  RECIP_ONE / 90,  RECIP_ONE / 91,
      RECIP_ONE / 92,  RECIP_ONE / 93,  RECIP_ONE / 94,  RECIP_ONE / 95,
      RECIP_ONE / 96,  RECIP_ONE / 97,  RECIP_ONE / 98,  RECIP_ONE / 99,
      RECIP_ONE / 100, RECIP_ONE / 101, RECIP_ONE / 102, RECIP_ONE / 103,
      RECIP_ONE / 104, RECIP_ONE / 105, RECIP_ONE / 106, RECIP_ONE / 107,
      RECIP_ONE / 108, RECIP_ONE / 109, RECIP_ONE / 110, RECIP_ONE / 111,
      RECIP_ONE / 112, RECIP_ONE / 113, RECIP_ONE / 114, RECIP_ONE / 115,
      RECIP_ONE / 116, RECIP_ONE / 117, RECIP_ONE / 118, RECIP_ONE / 119,
      RECIP_ONE / 120, RECIP_ONE / 121, RECIP_ONE / 122, RECIP_ONE / 123,
      RECIP_ONE / 124, RECIP_ONE / 125, RECIP_ONE / 126, RECIP_ONE / 127
   };

endpackage

`default_nettype wire

[hw/rtl/wfd_recip_div.sv]
// Three-stage pipelined divider of a 16-bit numerator by a 7-bit rate.
// Uses a precomputed reciprocal, one correction step; depends on wfd_pkg.
`default_nettype none

module wfd_recip_div (
   input  wire logic                           clock,
   input  wire logic                           advance,
   input  wire logic [wfd_pkg::NUM_W-1:0]      numer,
   input  wire logic [wfd_pkg::RATE_W-1:0]     divisor,
   input  wire logic [wfd_pkg::RECIP_W-1:0]    recip,
   output logic      [wfd_pkg::NUM_W-1:0]      quot
);

   localparam int unsigned NW = wfd_pkg::NUM_W;
   localparam int unsigned RW = wfd_pkg::RATE_W;

   logic [wfd_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [NW-1:0]              numer_a_ff;
   logic [RW-1:0]              div_a_ff;
   logic [NW-1:0]              q0_ff, q0_in;
   logic [NW-1:0]              qr_ff, qr_in;
   logic [NW-1:0]              numer_b_ff;
   logic [RW-1:0]              div_b_ff;
   logic [NW-1:0]              quot_ff, quot_in;
   logic [NW-1:0]              rem;

   // First stage: scale the numerator by the reciprocal.
   assign prod_in = {{wfd_pkg::RECIP_W{1'b0}}, numer} * {{NW{1'b0}}, recip};

   // Second stage: estimate is exact or one low; form estimate times rate.
   assign q0_in = prod_ff[2*NW-1:NW];
   assign qr_in = q0_in * {{(NW-RW){1'b0}}, div_a_ff};

   // Third stage: one compare and correct.
   assign rem     = numer_b_ff - qr_ff;
   assign quot_in = q0_ff + NW'(rem >= {{(NW-RW){1'b0}}, div_b_ff});

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff    <= prod_in;
         numer_a_ff <= numer;
         div_a_ff   <= divisor;
         q0_ff      <= q0_in;
         qr_ff      <= qr_in;
         numer_b_ff <= numer_a_ff;
         div_b_ff   <= div_a_ff;
         quot_ff    <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

[hw/rtl/wlan_frame_duration_calc_top.sv]
// Top level of the WLAN frame duration calculator: register file, input
// decode, three rate dividers and the duration sums. Depends on wfd_pkg
// and wfd_recip_div.
//
// Usage: each word on the req stream describes one transmit fragment
// (lengths, fragment flags, modulation, preamble, rate). For each word the
// rsp stream returns one word with the duration field and, for a first
// fragment, the RTS or CTS-to-self decision and its protection duration.
// Timing registers and the RTS threshold sit on the csr port at byte
// addresses 0x00 to 0x18 and are to be written by the user only while no
// word is in flight; the block does not enforce this. A result word goes
// through decode, the three divider stages and stage 5 to the rsp register.
// Throughput: one word per cycle; all six register stages advance
// together, so a new word can enter in every cycle in which the result
// register is free or being read. When the receiver holds rsp_tready low
// with a result waiting, the whole pipeline freezes and req_tready drops
// in the same cycle; nothing is lost or repeated. Synchronous reset empties
// the pipeline and restores each configuration register to its default.
`default_nettype none

module wlan_frame_duration_calc_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request stream.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [11:0] frame_length, [23:12] next_frame_length, [31:24] tx_rate
   input  wire logic [wfd_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [0] first_fragment, [1] group_address, [2] ofdm, [3] long_preamble
   input  wire logic [wfd_pkg::REQ_USER_W-1:0]      req_tuser,
   input  wire logic                                req_tlast,
   // Result stream.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [15:0] duration, [31:16] protect_duration
   output logic      [wfd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [0] protect_valid, [1] add_rts, [2] add_cts
   output logic      [wfd_pkg::RSP_USER_W-1:0]      rsp_tuser,
   // Register port.
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [wfd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [wfd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [wfd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                     csr_pready
);

   localparam int unsigned DW = wfd_pkg::DUR_W;
   localparam int unsigned NW = wfd_pkg::NUM_W;
   localparam int unsigned RW = wfd_pkg::RATE_W;
   localparam int unsigned CW = wfd_pkg::CSR_DATA_W;

   // Per-word control that travels beside the dividers.
   typedef struct packed {
      logic                      ofdm;
      logic                      rts;
      logic                      cts;
      logic                      group;
      logic                      last;
      logic [wfd_pkg::PRE_W-1:0] pre;
   } side_type;

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [wfd_pkg::SIFS_W-1:0] sifs_ff;
   logic [wfd_pkg::OPRE_W-1:0] ofdm_pre_ff;
   logic [wfd_pkg::SYM_W-1:0]  symbol_ff;
   logic [wfd_pkg::PRE_W-1:0]  long_pre_ff;
   logic [wfd_pkg::PRE_W-1:0]  short_pre_ff;
   logic [wfd_pkg::THR_W-1:0]  rts_thr_ff;
   logic                       protect_ff;

   wfd_pkg::csr_index_type csr_index;
   logic                   csr_write;

   assign csr_index  = wfd_pkg::csr_index_type'(csr_paddr[wfd_pkg::CSR_ADDR_W-1 -: 3]);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register writes at the access cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         sifs_ff      <= wfd_pkg::SIFS_W'(wfd_pkg::SIFS_RESET);
         ofdm_pre_ff  <= wfd_pkg::OPRE_W'(wfd_pkg::OFDM_PRE_RESET);
         symbol_ff    <= wfd_pkg::SYM_W'(wfd_pkg::SYMBOL_RESET);
         long_pre_ff  <= wfd_pkg::PRE_W'(wfd_pkg::LONG_PRE_RESET);
         short_pre_ff <= wfd_pkg::PRE_W'(wfd_pkg::SHORT_PRE_RESET);
         rts_thr_ff   <= wfd_pkg::THR_W'(wfd_pkg::RTS_THR_RESET);
         protect_ff   <= 1'(wfd_pkg::PROTECT_RESET);
      end else if (csr_write) begin
         case (csr_index)
            wfd_pkg::REG_SIFS:      sifs_ff      <= csr_pwdata[wfd_pkg::SIFS_W-1:0];
            wfd_pkg::REG_OFDM_PRE:  ofdm_pre_ff  <= csr_pwdata[wfd_pkg::OPRE_W-1:0];
            wfd_pkg::REG_SYMBOL:    symbol_ff    <= csr_pwdata[wfd_pkg::SYM_W-1:0];
            wfd_pkg::REG_LONG_PRE:  long_pre_ff  <= csr_pwdata[wfd_pkg::PRE_W-1:0];
            wfd_pkg::REG_SHORT_PRE: short_pre_ff <= csr_pwdata[wfd_pkg::PRE_W-1:0];
            wfd_pkg::REG_RTS_THR:   rts_thr_ff   <= csr_pwdata[wfd_pkg::THR_W-1:0];
            wfd_pkg::REG_PROTECT:   protect_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_index)
         wfd_pkg::REG_SIFS:      csr_prdata = CW'(sifs_ff);
         wfd_pkg::REG_OFDM_PRE:  csr_prdata = CW'(ofdm_pre_ff);
         wfd_pkg::REG_SYMBOL:    csr_prdata = CW'(symbol_ff);
         wfd_pkg::REG_LONG_PRE:  csr_prdata = CW'(long_pre_ff);
         wfd_pkg::REG_SHORT_PRE: csr_prdata = CW'(short_pre_ff);
         wfd_pkg::REG_RTS_THR:   csr_prdata = CW'(rts_thr_ff);
         wfd_pkg::REG_PROTECT:   csr_prdata = CW'(protect_ff);
         default:                csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Pipeline advance: every stage moves when the result register is free or being read.
   // ------------------------------------------------------------------
   logic rsp_valid_ff;
   logic advance;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // ------------------------------------------------------------------
   // Stage 1: decode the request word, form the numerators.
   // ------------------------------------------------------------------
   logic [wfd_pkg::LEN_W-1:0]  in_flen, in_nlen;
   logic [wfd_pkg::TXR_W-1:0]  in_txrate;
   logic                       in_first, in_group, in_ofdm, in_lpre;
   logic [RW-1:0]              rate_half;
   logic [wfd_pkg::BODY_W-1:0] body, nbody;
   logic [NW-1:0]              body_w, nbody_w, rate_w;

   logic          valid_s1_ff;
   side_type      side_s1_ff, side_s1_in;
   logic [RW-1:0] rate_s1_ff, rate_s1_in;
   logic [wfd_pkg::RECIP_W-1:0] recip_s1_ff, recip_s1_in;
   logic [NW-1:0] num_p_s1_ff, num_p_s1_in;
   logic [NW-1:0] num_d_s1_ff, num_d_s1_in;
   logic [NW-1:0] num_a_s1_ff, num_a_s1_in;

   assign in_flen   = req_tdata[11:0];
   assign in_nlen   = req_tdata[23:12];
   assign in_txrate = req_tdata[31:24];
   assign in_first  = req_tuser[0];
   assign in_group  = req_tuser[1];
   assign in_ofdm   = req_tuser[2];
   assign in_lpre   = req_tuser[3];

   // Rate in 1 Mb/s units, never below one.
   assign rate_half  = in_txrate[wfd_pkg::TXR_W-1:1];
   assign rate_s1_in = (rate_half == '0) ? RW'(1) : rate_half;
   assign recip_s1_in = wfd_pkg::RECIP_W'(wfd_pkg::RECIP_TABLE[rate_s1_in]);

   // Body lengths include the FCS.
   assign body    = wfd_pkg::BODY_W'(in_flen) + wfd_pkg::BODY_W'(wfd_pkg::FCS_LEN);
   assign nbody   = wfd_pkg::BODY_W'(in_nlen) + wfd_pkg::BODY_W'(wfd_pkg::FCS_LEN);
   assign body_w  = NW'(body);
   assign nbody_w = NW'(nbody);
   assign rate_w  = NW'(rate_s1_in);

   // Protection decision: RTS by length, else CTS-to-self for OFDM when protection is on.
   always_comb begin
      side_s1_in.ofdm  = in_ofdm;
      side_s1_in.group = in_group;
      side_s1_in.last  = req_tlast;
      side_s1_in.pre   = in_lpre ? long_pre_ff : short_pre_ff;
      side_s1_in.rts   = !in_group && in_first
                         && (body >= wfd_pkg::BODY_W'(rts_thr_ff));
      side_s1_in.cts   = !in_group && in_first && !side_s1_in.rts
                         && in_ofdm && protect_ff;
   end

   // Numerators for the three divisions by the rate. The OFDM symbol
   // count divides by four times the rate, so its numerator drops two bits.
   always_comb begin
      if (in_ofdm) begin
         num_p_s1_in = (body_w * NW'(8) + NW'(wfd_pkg::OFDM_EXTRA)
                        + rate_w * NW'(4) - NW'(1)) >> 2;
         num_d_s1_in = (nbody_w * NW'(8) + NW'(wfd_pkg::OFDM_EXTRA)
                        + rate_w * NW'(4) - NW'(1)) >> 2;
      end else begin
         num_p_s1_in = (body_w + NW'(wfd_pkg::RTS_DSSS_EXTRA)) * NW'(8)
                       + rate_w - NW'(1);
         num_d_s1_in = (nbody_w + NW'(wfd_pkg::DUR_DSSS_EXTRA)) * NW'(8)
                       + rate_w - NW'(1);
      end
      num_a_s1_in = NW'(wfd_pkg::ACK_BITS) + rate_w - NW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
      end else if (advance) begin
         valid_s1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_s1_ff  <= side_s1_in;
         rate_s1_ff  <= rate_s1_in;
         recip_s1_ff <= recip_s1_in;
         num_p_s1_ff <= num_p_s1_in;
         num_d_s1_ff <= num_d_s1_in;
         num_a_s1_ff <= num_a_s1_in;
      end
   end

   // ------------------------------------------------------------------
   // Stages 2 to 4: dividers, with the control word carried alongside.
   // ------------------------------------------------------------------
   logic [NW-1:0] quot_p, quot_d, quot_a;

   wfd_recip_div u_div_prot (
      .clock   (clock),
      .advance (advance),
      .numer   (num_p_s1_ff),
      .divisor (rate_s1_ff),
      .recip   (recip_s1_ff),
      .quot    (quot_p)
   );

   wfd_recip_div u_div_dur (
      .clock   (clock),
      .advance (advance),
      .numer   (num_d_s1_ff),
      .divisor (rate_s1_ff),
      .recip   (recip_s1_ff),
      .quot    (quot_d)
   );

   wfd_recip_div u_div_ack (
      .clock   (clock),
      .advance (advance),
      .numer   (num_a_s1_ff),
      .divisor (rate_s1_ff),
      .recip   (recip_s1_ff),
      .quot    (quot_a)
   );

   logic     valid_s2_ff, valid_s3_ff, valid_s4_ff;
   side_type side_s2_ff, side_s3_ff, side_s4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s2_ff <= 1'b0;
         valid_s3_ff <= 1'b0;
         valid_s4_ff <= 1'b0;
      end else if (advance) begin
         valid_s2_ff <= valid_s1_ff;
         valid_s3_ff <= valid_s2_ff;
         valid_s4_ff <= valid_s3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_s2_ff <= side_s1_ff;
         side_s3_ff <= side_s2_ff;
         side_s4_ff <= side_s3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: symbol-time products and the register-only terms.
   // ------------------------------------------------------------------
   logic [DW-1:0] sifs_w, opre_w, sym_w, pre_w;
   logic          valid_s5_ff;
   logic          prot_s5_ff, prot_s5_in;
   logic          rts_s5_ff, cts_s5_ff;
   logic [DW-1:0] pterm_s5_ff, pterm_s5_in;
   logic [DW-1:0] pbase_s5_ff, pbase_s5_in;
   logic [DW-1:0] dterm_s5_ff, dterm_s5_in;
   logic [DW-1:0] dbase_s5_ff, dbase_s5_in;

   assign sifs_w = DW'(sifs_ff);
   assign opre_w = DW'(ofdm_pre_ff);
   assign sym_w  = DW'(symbol_ff);
   assign pre_w  = DW'(side_s4_ff.pre);
   assign prot_s5_in = side_s4_ff.rts || side_s4_ff.cts;

   // Protection duration: RTS adds one more SIFS, preamble and response.
   always_comb begin
      if (side_s4_ff.ofdm) begin
         pterm_s5_in = quot_p * sym_w;
         if (side_s4_ff.rts) begin
            pbase_s5_in = sifs_w * DW'(3) + opre_w * DW'(3) + sym_w * DW'(4);
         end else begin
            pbase_s5_in = sifs_w * DW'(2) + opre_w * DW'(2) + sym_w * DW'(2);
         end
      end else begin
         pterm_s5_in = quot_p;
         if (side_s4_ff.rts) begin
            pbase_s5_in = pre_w * DW'(3) + quot_a + sifs_w * DW'(3);
         end else begin
            pbase_s5_in = pre_w * DW'(2) + sifs_w * DW'(2);
         end
      end
   end

   // Duration field: zero for group frames, ACK time for the last
   // fragment, else the next fragment plus its ACK.
   always_comb begin
      if (side_s4_ff.group) begin
         dterm_s5_in = '0;
         dbase_s5_in = '0;
      end else if (!side_s4_ff.last) begin
         if (side_s4_ff.ofdm) begin
            dterm_s5_in = quot_d * sym_w;
            dbase_s5_in = opre_w * DW'(3) + sym_w * DW'(3) + sifs_w * DW'(3);
         end else begin
            dterm_s5_in = quot_d;
            dbase_s5_in = pre_w * DW'(3) + sifs_w * DW'(3);
         end
      end else begin
         if (side_s4_ff.ofdm) begin
            dterm_s5_in = '0;
            dbase_s5_in = opre_w + sym_w * DW'(2) + sifs_w;
         end else begin
            dterm_s5_in = quot_a;
            dbase_s5_in = pre_w + sifs_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s5_ff <= 1'b0;
      end else if (advance) begin
         valid_s5_ff <= valid_s4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prot_s5_ff  <= prot_s5_in;
         rts_s5_ff   <= side_s4_ff.rts;
         cts_s5_ff   <= side_s4_ff.cts;
         pterm_s5_ff <= pterm_s5_in;
         pbase_s5_ff <= pbase_s5_in;
         dterm_s5_ff <= dterm_s5_in;
         dbase_s5_ff <= dbase_s5_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: final sums into the result register.
   // ------------------------------------------------------------------
   logic [DW-1:0] dur_ff, dur_in;
   logic [DW-1:0] pdur_ff, pdur_in;
   logic          prot_ff, rts_ff, cts_ff;

   assign dur_in  = dterm_s5_ff + dbase_s5_ff;
   assign pdur_in = prot_s5_ff ? (pterm_s5_ff + pbase_s5_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_s5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dur_ff  <= dur_in;
         pdur_ff <= pdur_in;
         prot_ff <= prot_s5_ff;
         rts_ff  <= rts_s5_ff;
         cts_ff  <= cts_s5_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {pdur_ff, dur_ff};
   assign rsp_tuser  = {cts_ff, rts_ff, prot_ff};

endmodule

`default_nettype wire

[hw/rtl/wfd_checker.sv]
// Port-level checks for the WLAN frame duration calculator, bound to the
// top level. Depends on wfd_pkg and wlan_frame_duration_calc_top.
`default_nettype none

module wfd_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [wfd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [wfd_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   // A stalled result word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                   && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // An empty result register never blocks the request side.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty result register");

   // RTS and CTS-to-self exclude each other; the flag summarizes both.
   a_prot_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[1] && rsp_tuser[2])
                     && (rsp_tuser[0] == (rsp_tuser[1] || rsp_tuser[2])))
      else $error("inconsistent protection flags");

   // Without protection the protection duration is zero.
   a_prot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[31:16] == '0)
      else $error("protection duration without protection");

endmodule

bind wlan_frame_duration_calc_top wfd_checker u_wfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

[verif/tb_wlan_frame_duration_calc_top.sv]
// Self-checking testbench for wlan_frame_duration_calc_top: it drives
// fragment descriptors and register writes and predicts every result word.
// Depends on wfd_pkg and the RTL of the duration calculator.
`default_nettype none

module tb_wlan_frame_duration_calc_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Frame arithmetic used by the duration predictor.
   localparam int unsigned FCS_BYTES      = 4;
   localparam int unsigned OFDM_TAIL_BITS = 22;
   localparam int unsigned RTS_OVERHEAD   = 14;
   localparam int unsigned DATA_OVERHEAD  = 28;
   localparam int unsigned ACK_LEN_BITS   = 112;

   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned SETTLE_CYCLES  = 20;
   localparam int unsigned PHASE_COUNT    = 8;
   localparam int unsigned PHASE_WORDS    = 190;

   typedef struct packed {
      logic [11:0] frame_len;
      logic [11:0] next_len;
      logic        first;
      logic        last;
      logic        group;
      logic        ofdm;
      logic        long_pre;
      logic [7:0]  tx_rate;
   } fragment_type;

   typedef struct packed {
      logic [15:0] duration;
      logic        protect_valid;
      logic        add_rts;
      logic        add_cts;
      logic [15:0] protect_duration;
   } duration_word_type;

   typedef struct packed {
      logic [7:0]  sifs;
      logic [7:0]  ofdm_pre;
      logic [3:0]  symbol;
      logic [8:0]  long_pre;
      logic [8:0]  short_pre;
      logic [11:0] rts_thr;
      logic        protect;
   } timing_cfg_type;

   // Predicts the duration word of each accepted fragment and checks the
   // words that come back against those predictions, oldest first.
   class duration_checker;
      int unsigned sifs, ofdm_pre, symbol, long_pre, short_pre, rts_thr, protect;
      duration_word_type expected_words[$];
      int unsigned error_count;

      function new();
         sifs        = 10;
         ofdm_pre    = 26;
         symbol      = 4;
         long_pre    = 192;
         short_pre   = 96;
         rts_thr     = 2347;
         protect     = 0;
         error_count = 0;
      endfunction

      function void set_register(wfd_pkg::csr_index_type idx, int unsigned value);
         case (idx)
            wfd_pkg::REG_SIFS:      sifs      = value & 32'hFF;
            wfd_pkg::REG_OFDM_PRE:  ofdm_pre  = value & 32'hFF;
            wfd_pkg::REG_SYMBOL:    symbol    = value & 32'hF;
            wfd_pkg::REG_LONG_PRE:  long_pre  = value & 32'h1FF;
            wfd_pkg::REG_SHORT_PRE: short_pre = value & 32'h1FF;
            wfd_pkg::REG_RTS_THR:   rts_thr   = value & 32'hFFF;
            wfd_pkg::REG_PROTECT:   protect   = value & 32'h1;
            default: ;
         endcase
      endfunction

      // Number of OFDM data symbols for a body of len bytes (rounded up).
      function int unsigned symbol_count(int unsigned len, int unsigned r);
         int unsigned d;
         d = r * 4;
         return (len * 8 + OFDM_TAIL_BITS + d - 1) / d;
      endfunction

      function duration_word_type predict_word(fragment_type f);
         int unsigned r, pre, body, nbody, pdur, dur;
         bit rts, cts;
         duration_word_type w;
         r = 32'(f.tx_rate) >> 1;
         if (r == 0) r = 1;
         pre   = f.long_pre ? long_pre : short_pre;
         body  = 32'(f.frame_len) + FCS_BYTES;
         nbody = 32'(f.next_len) + FCS_BYTES;
         rts   = 1'b0;
         cts   = 1'b0;
         pdur  = 0;

         // RTS wins over CTS-to-self; both only for a first unicast fragment.
         if (!f.group && f.first) begin
            if (body >= rts_thr) rts = 1'b1;
            else if (f.ofdm && protect != 0) cts = 1'b1;
         end

         if (rts || cts) begin
            if (f.ofdm) begin
               pdur = 2 * sifs + 2 * ofdm_pre + symbol_count(body, r) * symbol
                    + 2 * symbol;
               if (rts) pdur += sifs + ofdm_pre + 2 * symbol;
            end else begin
               pdur = 2 * pre + ((body + RTS_OVERHEAD) * 8 + r - 1) / r + 2 * sifs;
               if (rts) pdur += pre + (ACK_LEN_BITS + r - 1) / r + sifs;
            end
         end

         // Group frames carry zero; the last fragment covers only its ACK.
         if (f.group) begin
            dur = 0;
         end else if (!f.last) begin
            if (f.ofdm)
               dur = 3 * ofdm_pre + symbol_count(nbody, r) * symbol + 3 * symbol
                   + 3 * sifs;
            else
               dur = 3 * pre + ((nbody + DATA_OVERHEAD) * 8 + r - 1) / r + 3 * sifs;
         end else begin
            if (f.ofdm) dur = ofdm_pre + 2 * symbol + sifs;
            else        dur = pre + (ACK_LEN_BITS + r - 1) / r + sifs;
         end

         w.duration         = dur[15:0];
         w.protect_valid    = rts | cts;
         w.add_rts          = rts;
         w.add_cts          = cts;
         w.protect_duration = pdur[15:0];
         return w;
      endfunction

      function void note_fragment(fragment_type f);
         expected_words.push_back(predict_word(f));
      endfunction

      function void check_word(duration_word_type got);
         duration_word_type want;
         if (expected_words.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: result word with nothing expected: dur=%0d pdur=%0d",
                        $time, got.duration, got.protect_duration);
            return;
         end
         want = expected_words.pop_front();
         if (got.duration != want.duration || got.protect_valid != want.protect_valid ||
             got.add_rts != want.add_rts || got.add_cts != want.add_cts ||
             got.protect_duration != want.protect_duration) begin
            error_count++;
            if (error_count <= 10) begin
               $display("%0t: mismatch: expected dur=%0d pv=%0b rts=%0b cts=%0b pdur=%0d",
                        $time, want.duration, want.protect_valid, want.add_rts,
                        want.add_cts, want.protect_duration);
               $display("   got dur=%0d pv=%0b rts=%0b cts=%0b pdur=%0d",
                        got.duration, got.protect_valid, got.add_rts, got.add_cts,
                        got.protect_duration);
            end
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;
   logic [3:0]  req_tuser   = '0;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b1;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [4:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   duration_checker sb;
   bit          idle_enable = 1'b1;
   int unsigned stall_left  = 0;
   int unsigned quiet_cycles = 0;

   wlan_frame_duration_calc_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Result side: check each accepted word, then decide on stalls.
   always @(posedge clock) begin : rsp_side
      duration_word_type got;
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.duration         = rsp_tdata[15:0];
            got.protect_duration = rsp_tdata[31:16];
            got.protect_valid    = rsp_tuser[0];
            got.add_rts          = rsp_tuser[1];
            got.add_cts          = rsp_tuser[2];
            sb.check_word(got);
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 6);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run after too many cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Always advances before it checks, so valid changes land in new steps.
   task automatic wait_drained();
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Sends one fragment word; hold makes the sender wait for all results first.
   task automatic send_fragment(fragment_type f, bit hold = 1'b0);
      if (hold) begin
         req_tvalid <= 1'b0;
         wait_drained();
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {f.tx_rate, f.next_len, f.frame_len};
      req_tuser  <= {f.long_pre, f.ofdm, f.group, f.first};
      req_tlast  <= f.last;
      do @(posedge clock); while (!req_tready);
      sb.note_fragment(f);
   endtask

   // Ends a burst of words and waits for every result of it.
   task automatic close_burst();
      req_tvalid <= 1'b0;
      wait_drained();
   endtask

   // One register write; the caller releases the bus after its last write.
   task automatic write_register(wfd_pkg::csr_index_type idx, int unsigned value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(idx, value);
   endtask

   task automatic apply_config(timing_cfg_type c);
      write_register(wfd_pkg::REG_SIFS, 32'(c.sifs));
      write_register(wfd_pkg::REG_OFDM_PRE, 32'(c.ofdm_pre));
      write_register(wfd_pkg::REG_SYMBOL, 32'(c.symbol));
      write_register(wfd_pkg::REG_LONG_PRE, 32'(c.long_pre));
      write_register(wfd_pkg::REG_SHORT_PRE, 32'(c.short_pre));
      write_register(wfd_pkg::REG_RTS_THR, 32'(c.rts_thr));
      write_register(wfd_pkg::REG_PROTECT, 32'(c.protect));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic fragment_type make_fragment(int unsigned flen, int unsigned nlen,
                                                  bit first, bit last, bit group,
                                                  bit ofdm, bit long_pre,
                                                  int unsigned rate);
      fragment_type f;
      f.frame_len = 12'(flen);
      f.next_len  = 12'(nlen);
      f.first     = first;
      f.last      = last;
      f.group     = group;
      f.ofdm      = ofdm;
      f.long_pre  = long_pre;
      f.tx_rate   = 8'(rate);
      return f;
   endfunction

   // Favors the ends of a range.
   function automatic int unsigned pick_value(int unsigned top);
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return top;
         default: return $urandom_range(0, top);
      endcase
   endfunction

   function automatic timing_cfg_type random_timing();
      timing_cfg_type c;
      c.sifs      = 8'(pick_value(255));
      c.ofdm_pre  = 8'(pick_value(255));
      c.symbol    = 4'(pick_value(15));
      c.long_pre  = 9'(pick_value(511));
      c.short_pre = 9'(pick_value(511));
      c.rts_thr   = 12'(pick_value(4095));
      c.protect   = 1'($urandom_range(0, 1));
      return c;
   endfunction

   // Lengths cluster around the RTS threshold now and then.
   function automatic fragment_type random_fragment(int unsigned thr);
      fragment_type f;
      int t;
      case ($urandom_range(0, 9))
         0:       f.frame_len = '0;
         1:       f.frame_len = 12'd4095;
         2, 3: begin
            t = int'(thr) - int'(FCS_BYTES) + int'($urandom_range(0, 2)) - 1;
            f.frame_len = (t < 0) ? 12'd0 : ((t > 4095) ? 12'd4095 : 12'(t));
         end
         default: f.frame_len = 12'($urandom_range(0, 4095));
      endcase
      f.next_len = 12'(pick_value(4095));
      f.first    = 1'($urandom_range(0, 1));
      f.last     = 1'($urandom_range(0, 1));
      f.group    = ($urandom_range(0, 4) == 0);
      f.ofdm     = 1'($urandom_range(0, 1));
      f.long_pre = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0:       f.tx_rate = 8'($urandom_range(0, 3));
         1:       f.tx_rate = 8'($urandom_range(254, 255));
         default: f.tx_rate = 8'($urandom_range(0, 255));
      endcase
      return f;
   endfunction

   initial begin
      timing_cfg_type cfg;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words with the reset timing: rate extremes, threshold edge,
      // group frames, middle and last fragments of both modulations.
      send_fragment(make_fragment(0, 0, 1, 1, 0, 1, 0, 0));
      send_fragment(make_fragment(4095, 4095, 1, 0, 0, 0, 1, 255));
      send_fragment(make_fragment(4095, 4095, 1, 0, 0, 1, 0, 255));
      send_fragment(make_fragment(2343, 100, 1, 1, 0, 0, 0, 2));
      send_fragment(make_fragment(2342, 100, 1, 1, 0, 1, 0, 3));
      send_fragment(make_fragment(4095, 4095, 1, 0, 1, 1, 1, 255));
      send_fragment(make_fragment(1500, 0, 0, 0, 0, 1, 0, 108));
      send_fragment(make_fragment(1500, 4095, 0, 0, 0, 0, 0, 22));
      send_fragment(make_fragment(200, 0, 0, 1, 0, 0, 1, 1));
      send_fragment(make_fragment(0, 4095, 0, 1, 1, 0, 0, 254));
      send_fragment(make_fragment(3000, 2000, 0, 1, 0, 1, 1, 11));
      send_fragment(make_fragment(0, 0, 1, 0, 0, 0, 0, 4));
      close_burst();

      // Protection on: CTS-to-self for OFDM, RTS taking precedence at or above
      // the threshold, nothing for short DSSS, group or later fragments.
      cfg = '{sifs: 8'd10, ofdm_pre: 8'd26, symbol: 4'd4, long_pre: 9'd192,
              short_pre: 9'd96, rts_thr: 12'd1000, protect: 1'b1};
      apply_config(cfg);
      send_fragment(make_fragment(100, 200, 1, 0, 0, 1, 0, 12));
      send_fragment(make_fragment(100, 200, 1, 1, 0, 0, 0, 12));
      send_fragment(make_fragment(996, 50, 1, 1, 0, 1, 1, 96));
      send_fragment(make_fragment(995, 50, 1, 0, 0, 1, 0, 96));
      send_fragment(make_fragment(500, 0, 1, 1, 1, 1, 0, 48));
      send_fragment(make_fragment(500, 0, 0, 0, 0, 1, 0, 48));
      send_fragment(make_fragment(4095, 4095, 1, 0, 0, 0, 1, 0));
      send_fragment(make_fragment(0, 0, 1, 1, 0, 1, 1, 1));
      close_burst();

      // Random phases: all-ones timing, all-zero timing, then random ones.
      // The last phase runs without any idling.
      for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       cfg = '{8'hFF, 8'hFF, 4'hF, 9'h1FF, 9'h1FF, 12'hFFF, 1'b1};
            1:       cfg = '0;
            default: cfg = random_timing();
         endcase
         apply_config(cfg);
         idle_enable = (phase == PHASE_COUNT - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
         for (int unsigned n = 0; n < PHASE_WORDS; n++)
            send_fragment(random_fragment(32'(cfg.rts_thr)),
                          (n == PHASE_WORDS / 2) || ($urandom_range(0, 149) == 0));
         close_burst();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
